// ===== rtl/sim_pkg.sv =====
package sim_pkg;

    localparam int SET_DEPTH = 16;
    localparam int FILL_W    = $clog2(SET_DEPTH + 1);
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 16;
    localparam int OP_W      = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_PROBE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // Probe request as it walks down the row of cells.
    typedef struct packed {
        logic                     valid;
        logic signed [VALUE_W-1:0] value;
        logic [FILL_W-1:0]        snap;
        logic                     hit;
    } probe_t;

    // Store write from the load path to every cell.
    typedef struct packed {
        logic                      en;
        logic [FILL_W-1:0]         addr;
        logic signed [VALUE_W-1:0] data;
    } store_wr_t;

endpackage

// ===== rtl/sim_cell.sv =====
module sim_cell
    import sim_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [FILL_W-1:0] cell_idx,
    input  logic              advance,
    input  store_wr_t         wr,
    input  probe_t            probe_in,
    output probe_t            probe_out
);

    logic signed [VALUE_W-1:0] entry_reg;
    probe_t                    stage_reg;
    probe_t                    stage_next;

    // Only entries filled before the probe was taken may match.
    always_comb begin
        stage_next     = probe_in;
        stage_next.hit = probe_in.hit
                         | ((cell_idx < probe_in.snap) && (entry_reg == probe_in.value));
    end

    always_ff @(posedge aclk) begin
        if (wr.en && (wr.addr == cell_idx)) begin
            entry_reg <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg <= stage_next;
        end
    end

    assign probe_out = stage_reg;

endmodule

// ===== rtl/sim_out.sv =====
module sim_out
    import sim_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  clear,
    input  probe_t                tail,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic                      valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      hit_reg;
    logic [COUNT_W-1:0]        res_count_reg;

    always_comb begin
        count_next = count_reg;
        if (tail.valid && tail.hit && (count_reg != COUNT_MAX)) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (clear) begin
                count_reg <= '0;
            end else if (advance) begin
                count_reg <= count_next;
            end
            if (advance) begin
                valid_reg <= tail.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && tail.valid) begin
            value_reg     <= tail.value;
            hit_reg       <= tail.hit;
            res_count_reg <= count_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - VALUE_W - 1 - COUNT_W){1'b0}},
                       res_count_reg, hit_reg, value_reg};

endmodule

// ===== rtl/set_intersection_match.sv =====
// Set intersection by nested-loop match. Load requests append a signed 32-bit
// value to a store of SET_DEPTH entries (extra loads are dropped); a clear
// request empties the store and zeroes the match count. Each probe request
// walks down a row of SET_DEPTH cells, one cell per cycle while the result side
// keeps up, each cell holding one store entry and comparing it with the passing
// probe; the result is offered from the output register behind the last cell
// with the echoed value, a match flag and a running match count that saturates
// at 65535. A new request is taken every cycle while the result side keeps up;
// a clear waits until every probe already in the row has left it, which takes
// longer while the result side stalls.
// Loads never disturb probes in flight: each probe carries the fill level seen
// when it was taken and only compares entries below it.
module set_intersection_match
    import sim_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] item_value
    input  logic [OP_W-1:0]       s_tuser,   // [1:0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] probe_value, [32] is_common,
                                             // [48:33] common_count, rest zero
);

    opcode_t           op;
    logic              advance;
    logic              busy;
    logic              s_accept;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    store_wr_t         wr;
    probe_t            chain [0:SET_DEPTH];
    logic [SET_DEPTH-1:0] stage_valid;

    assign op = opcode_t'(s_tuser);

    // Move the whole row whenever the output register is free or being drained.
    assign advance = !m_tvalid || m_tready;

    // Hold a clear until the row is empty; everything else rides the row.
    assign s_tready = advance && !((op == OP_CLEAR) && busy);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        fill_next = fill_reg;
        wr.en     = 1'b0;
        wr.addr   = fill_reg;
        wr.data   = s_tdata[VALUE_W-1:0];
        if (s_accept) begin
            case (op)
                OP_CLEAR: begin
                    fill_next = '0;
                end
                OP_LOAD: begin
                    if (fill_reg < FILL_W'(SET_DEPTH)) begin
                        wr.en     = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Launch a probe into the head of the row.
    always_comb begin
        chain[0].valid = s_accept && (op == OP_PROBE);
        chain[0].value = s_tdata[VALUE_W-1:0];
        chain[0].snap  = fill_reg;
        chain[0].hit   = 1'b0;
    end

    for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
        sim_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (FILL_W'(i)),
            .advance   (advance),
            .wr        (wr),
            .probe_in  (chain[i]),
            .probe_out (chain[i+1])
        );
        assign stage_valid[i] = chain[i+1].valid;
    end

    assign busy = |stage_valid;

    sim_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .clear    (s_accept && (op == OP_CLEAR)),
        .tail     (chain[SET_DEPTH]),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    // A clear must never overtake a probe still in the row.
    a_clear_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (op == OP_CLEAR)) |-> !busy)
        else $error("clear accepted with probes in flight");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(SET_DEPTH))
        else $error("fill level beyond store depth");

    a_probe_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (op == OP_PROBE)) |=> chain[1].valid)
        else $error("accepted probe missing from first cell");

    a_load_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |=> (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("store write without fill advance");

endmodule

// ===== tb/set_match_checker.sv =====
`timescale 1ns / 100ps

module set_match_checker
    import sim_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] item_value
    input  logic [OP_W-1:0]       s_tuser,   // [1:0] opcode
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] probe_value, [32] is_common,
                                             // [48:33] common_count, rest zero
    output int                    mismatches,
    output int                    pending_results,
    output int                    results_checked,
    output int                    hits_checked
);

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               common;
        logic [COUNT_W-1:0] count;
    } probe_outcome_t;

    logic [VALUE_W-1:0] entries [SET_DEPTH];
    int                 fill_level;
    logic [COUNT_W-1:0] match_tally;
    probe_outcome_t     awaited_results [$];
    int                 mismatch_tally;
    int                 result_tally;
    int                 hit_tally;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_tally++;
        // keep the log readable on a badly broken block; the count stays exact
        if (mismatch_tally <= PRINT_CAP)
            $display("%0t ns: mismatch in %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Advance the local copy of the store and count by one accepted request.
    task automatic apply_request(input opcode_t op, input logic [VALUE_W-1:0] value);
        probe_outcome_t outcome;
        logic           hit;
        int             k;
        case (op)
            OP_CLEAR: begin
                fill_level  = 0;
                match_tally = '0;
            end
            OP_LOAD: begin
                if (fill_level < SET_DEPTH) begin
                    entries[fill_level] = value;
                    fill_level++;
                end
            end
            OP_PROBE: begin
                hit = 1'b0;
                for (k = 0; k < fill_level; k++)
                    if (entries[k] == value)
                        hit = 1'b1;
                if (hit && match_tally != COUNT_MAX)
                    match_tally++;
                outcome.value  = value;
                outcome.common = hit;
                outcome.count  = match_tally;
                awaited_results.push_back(outcome);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] data);
        probe_outcome_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch("result with no probe outstanding", 64'(data), '0);
        end else begin
            want = awaited_results.pop_front();
            result_tally++;
            if (want.common)
                hit_tally++;
            if (data[31:0] != want.value)
                report_mismatch("probe_value", 64'(data[31:0]), 64'(want.value));
            if (data[32] != want.common)
                report_mismatch("is_common", 64'(data[32]), 64'(want.common));
            if (data[48:33] != want.count)
                report_mismatch("common_count", 64'(data[48:33]), 64'(want.count));
            if (data[OUT_DATA_W-1:49] != '0)
                report_mismatch("padding bits", 64'(data[OUT_DATA_W-1:49]), '0);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_level  = 0;
            match_tally = '0;
            awaited_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                apply_request(opcode_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
        end
        mismatches      <= mismatch_tally;
        pending_results <= awaited_results.size();
        results_checked <= result_tally;
        hits_checked    <= hit_tally;
    end

endmodule

// ===== tb/set_intersection_match_test.sv =====
`timescale 1ns / 100ps

module set_intersection_match_test;
    import sim_pkg::*;

    localparam int RANDOM_ITEMS  = 1800;
    localparam int DRAIN_LIMIT   = 20000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // [31:0] item_value
    logic [OP_W-1:0]       s_tuser;    // [1:0] opcode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // [31:0] probe_value, [32] is_common,
                                       // [48:33] common_count, rest zero

    int mismatches;
    int pending_results;
    int results_checked;
    int hits_checked;

    // When set, neither side idles: back-to-back requests and no result stalls.
    logic steady_flow;
    int   hold_left;
    int   requests_sent;
    int   random_sent;
    int   sequences;

    set_intersection_match u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    set_match_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .hits_checked    (hits_checked)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Gap lengths drawn from three bands: mostly the shortest, sometimes the middle one, rarely a long pause.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 2);
        else if (r < 90)
            return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    // Mix fully random values with a small clustered range and the signed extremes,
    // so that loads and probes collide often enough to give hits.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom;
        else if (r < 8)
            return $urandom_range(0, 15) - 8;
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Result side: hold tready low for random stretches unless steady flow is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
        end else if (steady_flow || hold_left == 0) begin
            m_tready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 99) < 25)
                hold_left = gap_length();
        end else begin
            m_tready <= 1'b0;
            hold_left--;
        end
    end

    // Offer one request and hold it until the block takes it. Drop tvalid only when
    // a gap is wanted, so a back-to-back request never lowers and raises it in one step.
    task automatic push_request(input opcode_t op, input logic [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 1) == 1)
            gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        // unused opcodes change nothing, so leave them out of the tally
        if (op != OP_NONE) begin
            requests_sent++;
            random_sent++;
        end
    endtask

    // One clear, a burst of loads (sometimes past capacity), then probes that mostly
    // target loaded values, with near misses, late loads and ignored codes mixed in.
    task automatic run_set_sequence();
        logic [VALUE_W-1:0] loaded [$];
        logic [VALUE_W-1:0] v;
        int                 n_loads;
        int                 n_probes;
        int                 r;
        int                 i;
        push_request(OP_CLEAR, $urandom);
        n_loads = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20)
                                              : $urandom_range(0, 10);
        for (i = 0; i < n_loads; i++) begin
            v = pick_value();
            loaded.push_back(v);
            push_request(OP_LOAD, v);
        end
        n_probes = $urandom_range(1, 30);
        for (i = 0; i < n_probes; i++) begin
            r = $urandom_range(0, 19);
            if (r < 11 && loaded.size() > 0) begin
                push_request(OP_PROBE, loaded[$urandom_range(0, loaded.size() - 1)]);
            end else if (r < 15) begin
                push_request(OP_PROBE, pick_value());
            end else if (r < 17 && loaded.size() > 0) begin
                // flip one bit of a stored value: must miss unless it hits another entry
                push_request(OP_PROBE, loaded[$urandom_range(0, loaded.size() - 1)]
                                       ^ (32'd1 << $urandom_range(0, 31)));
            end else if (r == 17) begin
                v = pick_value();
                loaded.push_back(v);
                push_request(OP_LOAD, v);
            end else if (r == 18) begin
                push_request(OP_NONE, $urandom);
            end else begin
                push_request(OP_PROBE, $urandom);
            end
        end
    endtask

    initial begin : stimulus
        int n;
        int i;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_CLEAR;
        steady_flow   = 1'b0;
        requests_sent = 0;
        random_sent   = 0;
        sequences     = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-store probe, ignored code, the signed extremes,
        // repeated probes, a duplicated entry and a clear followed by a miss.
        push_request(OP_PROBE, 32'h0000_0000);
        push_request(OP_NONE,  32'h7FFF_FFFF);
        push_request(OP_LOAD,  32'h8000_0000);
        push_request(OP_LOAD,  32'h7FFF_FFFF);
        push_request(OP_LOAD,  32'hFFFF_FFFF);
        push_request(OP_LOAD,  32'h0000_0000);
        push_request(OP_PROBE, 32'h8000_0000);
        push_request(OP_PROBE, 32'h7FFF_FFFF);
        push_request(OP_PROBE, 32'hFFFF_FFFF);
        push_request(OP_PROBE, 32'h0000_0000);
        push_request(OP_PROBE, 32'h7FFF_FFFF);
        push_request(OP_PROBE, 32'h0000_0001);
        push_request(OP_PROBE, 32'hFFFF_FFFE);
        push_request(OP_NONE,  32'h0000_0001);
        push_request(OP_LOAD,  32'h0000_0000);
        push_request(OP_PROBE, 32'h0000_0000);
        push_request(OP_CLEAR, 32'hFFFF_FFFF);
        push_request(OP_PROBE, 32'h8000_0000);
        push_request(OP_PROBE, 32'h0000_0000);

        // Random: mostly well-formed set sequences, the rest loose noise that
        // includes stray clears, loads without a clear and unused codes.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            steady_flow <= ($urandom_range(0, 3) == 0);
            sequences++;
            if ($urandom_range(0, 9) < 8) begin
                run_set_sequence();
            end else begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    push_request(opcode_t'($urandom_range(0, 3)), pick_value());
            end
        end
        s_tvalid    <= 1'b0;
        steady_flow <= 1'b0;

        // Drain: wait for every outstanding result, then longer than a probe takes to cross
        // the row, so that any stray result still surfaces.
        for (n = 0; n < DRAIN_LIMIT && pending_results != 0; n++)
            @(posedge aclk);
        repeat (SET_DEPTH + 8) @(posedge aclk);

        $display("Sent %0d requests (%0d random, %0d random sequences) under mixed stalls.",
                 requests_sent, random_sent, sequences);
        $display("Checked %0d probe results, %0d of them hits; %0d mismatches, %0d left over.",
                 results_checked, hits_checked, mismatches, pending_results);
        if (mismatches == 0 && pending_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: a time limit several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
